// ===== hw/rtl/fpa_pkg.sv =====
// Shared constants for the first-fit pool allocator.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int unsigned VW = 40;  // offset / size / total width
    localparam int unsigned SW = 5;   // alignment shift width

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOMEM    = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // register indexes (paddr[3])
    localparam logic REG_POOL_SIZE   = 1'b0;
    localparam logic REG_ALIGN_SHIFT = 1'b1;

    localparam logic [SW-1:0] ALIGN_RESET = 5'd12;

endpackage

// ===== hw/rtl/first_fit_pool_allocator_top.sv =====
// First-fit pool allocator: a sorted block table walked by a small sequencer.
//
// Usage: one request item enters on the s_ channel (s_tuser = action, 0 allocate,
// 1 free; s_tdata = request_size, block_offset). Exactly one result item leaves
// on the m_ channel (m_tuser = status; m_tdata = result_offset, bytes_in_use).
// pool_size (byte address 0) and align_shift (byte address 8) are written over
// the APB port; the user must do so only while no request is in flight, which
// the block itself does not enforce. The block table sits in a single-port-read
// memory with registered read data, so every table entry touched takes a read
// state and then a use state. An allocate walks the table once to find the gap
// and once more to find the insertion point, then moves the entries above it up
// by one. A free scans up to the match and moves the entries above it down. One
// request at a time: s_tready is low from acceptance until the result item is
// taken. When the receiver stalls, the result item holds on m_tdata/m_tuser and
// no new request is taken. Reset empties the table (live count and byte total
// cleared), sets pool_size to 0 and align_shift to 12; no clearing pass.
`timescale 1ns / 1ps

module first_fit_pool_allocator_top
    import fpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [39:0] request_size, [79:40] block_offset
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [39:0] result_offset, [79:40] bytes_in_use
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD, S_A_CMP, S_A_CHK, S_P_RD, S_P_CMP, S_DECIDE,
        S_U_RD, S_U_WR, S_INS, S_F_RD, S_F_CMP, S_D_RD, S_D_WR, S_OUT
    } state_t;

    // ---------------- configuration ----------------
    logic [VW-1:0] pool_size_reg;
    logic [SW-1:0] align_shift_reg;
    logic          cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg   <= '0;
            align_shift_reg <= ALIGN_RESET;
        end else if (cfg_we) begin
            case (paddr[3])
                REG_POOL_SIZE:   pool_size_reg   <= pwdata[VW-1:0];
                REG_ALIGN_SHIFT: align_shift_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_POOL_SIZE:   prdata = {24'd0, pool_size_reg};
            REG_ALIGN_SHIFT: prdata = {59'd0, align_shift_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- block table memory: {length, start} ----------------
    logic [2*VW-1:0] mem [MAX_BLOCKS];
    logic [2*VW-1:0] rdata_reg;
    logic [AW-1:0]   raddr_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [2*VW-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr_reg];
    end

    logic [VW-1:0] rd_start, rd_len;
    assign rd_start = rdata_reg[VW-1:0];
    assign rd_len   = rdata_reg[2*VW-1:VW];

    // ---------------- sequencer ----------------
    state_t        state_reg;
    logic [VW-1:0] size_reg;
    logic [VW-1:0] where_reg;
    logic [VW+1:0] off_reg;       // candidate may run past 40 bits
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] live_reg;
    logic [VW-1:0] used_reg;
    status_t       status_reg;
    logic [VW-1:0] res_off_reg;

    // shared arithmetic
    logic [VW+2:0] off_end;       // off + size
    logic [VW+1:0] amask;
    logic [VW+1:0] blk_end;
    logic [VW+1:0] rounded;

    assign off_end = {1'b0, off_reg} + {3'b0, size_reg};
    assign amask   = (VW+2)'(({{(VW+1){1'b0}}, 1'b1} << align_shift_reg) - 1'b1);
    assign blk_end = {2'b0, rd_start} + {2'b0, rd_len};
    assign rounded = (blk_end + amask) & ~amask;

    always_comb begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata_reg;
        case (state_reg)
            S_P_CMP: begin
                we    = (rd_start == off_reg[VW-1:0]) && (off_reg[VW+1:VW] == 2'b0);
                wdata = {rd_len + size_reg, rd_start};
            end
            S_U_WR:  we = 1'b1;
            S_D_WR:  we = 1'b1;
            S_INS: begin
                we    = 1'b1;
                waddr = pos_reg[AW-1:0];
                wdata = {size_reg, off_reg[VW-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            used_reg  <= '0;
            m_tvalid  <= 1'b0;
            raddr_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        size_reg   <= s_tdata[VW-1:0];
                        where_reg  <= s_tdata[2*VW-1:VW];
                        off_reg    <= '0;
                        idx_reg    <= '0;
                        raddr_reg  <= '0;
                        res_off_reg <= '0;
                        if (s_tuser == ACT_FREE) begin
                            if (live_reg == '0) begin
                                status_reg <= ST_NOTFOUND;
                                state_reg  <= S_OUT;
                                m_tvalid   <= 1'b1;
                            end else begin
                                state_reg <= S_F_RD;
                            end
                        end else begin
                            state_reg <= (live_reg == '0) ? S_A_CHK : S_A_RD;
                        end
                    end
                end
                S_A_RD: state_reg <= S_A_CMP;
                S_A_CMP: begin
                    if (off_end > {3'b0, rd_start}) begin
                        off_reg <= rounded;
                        idx_reg <= idx_reg + ONE;
                        raddr_reg <= AW'(idx_reg + ONE);
                        state_reg <= (idx_reg + ONE < live_reg) ? S_A_RD : S_A_CHK;
                    end else begin
                        state_reg <= S_A_CHK;
                    end
                end
                S_A_CHK: begin
                    idx_reg   <= '0;
                    raddr_reg <= '0;
                    if (off_end > {3'b0, pool_size_reg}) begin
                        status_reg <= ST_NOMEM;
                        m_tvalid   <= 1'b1;
                        state_reg  <= S_OUT;
                    end else if (live_reg == '0) begin
                        pos_reg   <= '0;
                        state_reg <= S_DECIDE;
                    end else begin
                        state_reg <= S_P_RD;
                    end
                end
                S_P_RD: state_reg <= S_P_CMP;
                S_P_CMP: begin
                    if ({2'b0, rd_start} < off_reg) begin
                        idx_reg   <= idx_reg + ONE;
                        raddr_reg <= AW'(idx_reg + ONE);
                        if (idx_reg + ONE < live_reg) begin
                            state_reg <= S_P_RD;
                        end else begin
                            pos_reg   <= live_reg;
                            state_reg <= S_DECIDE;
                        end
                    end else if ({2'b0, rd_start} == off_reg) begin
                        // same start already live: grow that entry
                        used_reg    <= used_reg + size_reg;
                        status_reg  <= ST_OK;
                        res_off_reg <= off_reg[VW-1:0];
                        m_tvalid    <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        pos_reg   <= idx_reg;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (live_reg == MAX_CNT) begin
                        status_reg <= ST_FULL;
                        m_tvalid   <= 1'b1;
                        state_reg  <= S_OUT;
                    end else if (live_reg > pos_reg) begin
                        idx_reg   <= live_reg;
                        raddr_reg <= AW'(live_reg - ONE);
                        state_reg <= S_U_RD;
                    end else begin
                        state_reg <= S_INS;
                    end
                end
                S_U_RD: state_reg <= S_U_WR;
                S_U_WR: begin
                    // entry idx-1 moved up to idx
                    idx_reg   <= idx_reg - ONE;
                    raddr_reg <= AW'(idx_reg - ONE - ONE);
                    state_reg <= (idx_reg - ONE > pos_reg) ? S_U_RD : S_INS;
                end
                S_INS: begin
                    live_reg    <= live_reg + ONE;
                    used_reg    <= used_reg + size_reg;
                    status_reg  <= ST_OK;
                    res_off_reg <= off_reg[VW-1:0];
                    m_tvalid    <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_F_RD: state_reg <= S_F_CMP;
                S_F_CMP: begin
                    if (rd_start == where_reg) begin
                        used_reg <= used_reg - rd_len;
                        if (idx_reg + ONE < live_reg) begin
                            raddr_reg <= AW'(idx_reg + ONE);
                            state_reg <= S_D_RD;
                        end else begin
                            live_reg   <= live_reg - ONE;
                            status_reg <= ST_OK;
                            m_tvalid   <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                    end else if (idx_reg + ONE < live_reg) begin
                        idx_reg   <= idx_reg + ONE;
                        raddr_reg <= AW'(idx_reg + ONE);
                        state_reg <= S_F_RD;
                    end else begin
                        status_reg <= ST_NOTFOUND;
                        m_tvalid   <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_D_RD: state_reg <= S_D_WR;
                S_D_WR: begin
                    // entry idx+1 moved down to idx
                    idx_reg <= idx_reg + ONE;
                    if (idx_reg + ONE + ONE < live_reg) begin
                        raddr_reg <= AW'(idx_reg + ONE + ONE);
                        state_reg <= S_D_RD;
                    end else begin
                        live_reg   <= live_reg - ONE;
                        status_reg <= ST_OK;
                        m_tvalid   <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tuser  = status_reg;
    assign m_tdata  = {used_reg, res_off_reg};

    // ---------------- assertions ----------------
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= MAX_CNT) else $error("live count above table depth");

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready right after accept");

    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[VW-1:0] == '0))
        else $error("nonzero offset on failed request");

endmodule

// ===== sim/fpa_checker.sv =====
// Checker for the first-fit pool allocator: block table prediction and result compare.
`timescale 1ns / 1ps

module fpa_checker
    import fpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        end_of_test,
    output int          fail_count
);

    localparam int TABLE_DEPTH = 32;

    typedef struct packed {
        status_t       status;
        logic [VW-1:0] offset;
        logic [VW-1:0] in_use;
    } outcome_t;

    logic [VW-1:0] blk_start [TABLE_DEPTH];
    logic [VW-1:0] blk_len   [TABLE_DEPTH];
    int            n_live;
    logic [VW-1:0] used_bytes;
    logic [VW-1:0] pool_bytes;
    logic [SW-1:0] shift;
    outcome_t      pending_q [$];
    bit            leftovers_counted;

    function automatic logic [63:0] round_to_align(logic [63:0] v);
        logic [63:0] a;
        a = 64'd1 << shift;
        return (v + (a - 64'd1)) & ~(a - 64'd1);
    endfunction

    function automatic outcome_t apply_request(logic act, logic [VW-1:0] sz,
                                               logic [VW-1:0] where);
        outcome_t    r;
        logic [63:0] cand;
        int          pos;
        bit          walking;
        r = '{status: ST_OK, offset: '0, in_use: '0};
        if (act == ACT_ALLOC) begin
            cand = 64'd0;
            walking = 1;
            for (int i = 0; i < n_live; i++) begin
                if (walking) begin
                    if (cand + sz > blk_start[i])
                        cand = round_to_align(64'(blk_start[i]) + blk_len[i]);
                    else
                        walking = 0;
                end
            end
            if (cand + sz > pool_bytes) begin
                r.status = ST_NOMEM;
            end else begin
                pos = 0;
                while (pos < n_live && blk_start[pos] < cand)
                    pos++;
                if (pos < n_live && blk_start[pos] == cand) begin
                    // zero-size request or zero-length block sharing a start: grow in place
                    blk_len[pos] = blk_len[pos] + sz;
                    used_bytes = used_bytes + sz;
                    r.offset = cand[VW-1:0];
                end else if (n_live >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = n_live; i > pos; i--) begin
                        blk_start[i] = blk_start[i-1];
                        blk_len[i] = blk_len[i-1];
                    end
                    blk_start[pos] = cand[VW-1:0];
                    blk_len[pos] = sz;
                    n_live++;
                    used_bytes = used_bytes + sz;
                    r.offset = cand[VW-1:0];
                end
            end
        end else begin
            pos = 0;
            while (pos < n_live && blk_start[pos] != where)
                pos++;
            if (pos >= n_live) begin
                r.status = ST_NOTFOUND;
            end else begin
                used_bytes = used_bytes - blk_len[pos];
                for (int i = pos; i + 1 < n_live; i++) begin
                    blk_start[i] = blk_start[i+1];
                    blk_len[i] = blk_len[i+1];
                end
                n_live--;
            end
        end
        r.in_use = used_bytes;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            fail_count = 0;
            n_live = 0;
            used_bytes = '0;
            pool_bytes = '0;
            shift = ALIGN_RESET;
            pending_q.delete();
            leftovers_counted = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 4'd0)
                    pool_bytes = pwdata[VW-1:0];
                else if (paddr == 4'd8)
                    shift = pwdata[SW-1:0];
            end
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected result item", {62'd0, m_tuser}, 64'd0);
                end else begin
                    want = pending_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(m_tuser), 64'(want.status));
                    if (m_tdata[39:0] !== want.offset)
                        report_mismatch("result_offset", 64'(m_tdata[39:0]),
                                        64'(want.offset));
                    if (m_tdata[79:40] !== want.in_use)
                        report_mismatch("bytes_in_use", 64'(m_tdata[79:40]),
                                        64'(want.in_use));
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(apply_request(s_tuser, s_tdata[39:0], s_tdata[79:40]));
            if (end_of_test && !leftovers_counted) begin
                leftovers_counted = 1;
                if (pending_q.size() != 0)
                    report_mismatch("results never returned", 64'(pending_q.size()), 64'd0);
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top-level testbench: stimulus, configuration phases and verdict for the pool allocator.
`timescale 1ns / 1ps

module testbench;
    import fpa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        end_of_test = 0;
    int          fail_count;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          n_sent = 0;
    int          n_done = 0;
    int          n_ok = 0;
    int          n_nomem = 0;
    int          n_notfound = 0;
    int          n_full = 0;
    int          quiet_cycles = 0;
    logic        act_q [$];
    logic [39:0] granted [$];

    always #5 aclk = ~aclk;

    first_fit_pool_allocator_top u_dut (.*);

    fpa_checker u_checker (.*);

    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= stall_pct);

    // follow granted offsets so the stimulus can free live blocks
    always @(posedge aclk) begin
        logic act;
        if (s_tvalid && s_tready)
            act_q.push_back(s_tuser);
        if (m_tvalid && m_tready) begin
            n_done++;
            act = act_q.pop_front();
            case (m_tuser)
                ST_OK: begin
                    n_ok++;
                    if (act == ACT_ALLOC)
                        granted.push_back(m_tdata[39:0]);
                end
                ST_NOMEM: n_nomem++;
                ST_NOTFOUND: n_notfound++;
                default: n_full++;
            endcase
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(logic act, logic [39:0] sz, logic [39:0] where);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tuser = act;
        s_tdata = {where, sz};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid = 0;
        while (n_done != n_sent)
            @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [63:0] value);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = addr;
        pwdata = value;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic configure(logic [39:0] pool, logic [4:0] sh);
        drain();
        // upper data bits are don't-care; keep them toggling
        write_reg(4'd0, {$urandom, $urandom} & ~64'hFF_FFFF_FFFF | 64'(pool));
        write_reg(4'd8, {$urandom, $urandom} & ~64'h1F | 64'(sh));
    endtask

    function automatic logic [39:0] pick_size(logic [39:0] scale);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(19))
            0: return '0;
            1: return r[39:0];
            default: return 40'(r % (64'(scale) + 64'd1));
        endcase
    endfunction

    task automatic random_burst(int count, logic [39:0] scale, int free_pct);
        int          k;
        logic [39:0] noise;
        for (int i = 0; i < count; i++) begin
            noise = 40'({$urandom, $urandom});
            if (i % 30 == 0) begin
                case ((i / 30) % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 55; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 55; end
                    default: begin idle_pct = 22; stall_pct = 22; end
                endcase
            end
            if ($urandom_range(99) < free_pct) begin
                drain();
                if (granted.size() != 0 && $urandom_range(9) != 0) begin
                    k = $urandom_range(granted.size() - 1);
                    send_request(ACT_FREE, noise, granted[k]);
                    granted.delete(k);
                end else begin
                    send_request(ACT_FREE, noise, 40'({$urandom, $urandom}));
                end
            end else begin
                send_request(ACT_ALLOC, pick_size(scale), noise);
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: reset config (empty pool), extremes, merges, misses
        send_request(ACT_ALLOC, 40'd0, 40'hFF_FFFF_FFFF);
        send_request(ACT_ALLOC, 40'd0, 40'd0);
        send_request(ACT_ALLOC, 40'd1, 40'd0);
        send_request(ACT_FREE, 40'hFF_FFFF_FFFF, 40'd0);
        send_request(ACT_FREE, 40'd0, 40'hFF_FFFF_FFFF);
        configure(40'd65536, 5'd12);
        send_request(ACT_ALLOC, 40'hFF_FFFF_FFFF, 40'd0);
        send_request(ACT_ALLOC, 40'd100, 40'd0);
        send_request(ACT_ALLOC, 40'd0, 40'd0);
        send_request(ACT_ALLOC, 40'd5000, 40'd0);
        send_request(ACT_ALLOC, 40'd65536, 40'd0);
        send_request(ACT_FREE, 40'd0, 40'd4096);
        send_request(ACT_FREE, 40'd0, 40'd4096);
        send_request(ACT_ALLOC, 40'd4096, 40'd0);
        configure(40'hFF_FFFF_FFFF, 5'd31);
        send_request(ACT_ALLOC, 40'd1, 40'd0);
        send_request(ACT_ALLOC, 40'hFF_FFFF_FFFF, 40'd0);
        send_request(ACT_FREE, 40'd0, 40'd0);
        send_request(ACT_FREE, 40'd0, 40'd0);
        send_request(ACT_FREE, 40'd0, 40'd4096);
        send_request(ACT_FREE, 40'd0, 40'd12288);
        drain();
        granted.delete();

        configure(40'hFF_FFFF_FFFF, 5'd0);
        random_burst(195, 40'd16, 15);
        configure(40'd65536, 5'd12);
        random_burst(115, 40'd8192, 40);
        configure(40'd262144, 5'd4);
        random_burst(115, 40'd20000, 40);
        configure(40'd1048576, 5'd31);
        random_burst(100, 40'd4096, 40);
        configure(40'd4096, 5'd30);
        random_burst(100, 40'd1024, 40);
        configure(40'hFF_FFFF_FFFF, 5'd30);
        random_burst(100, 40'h10_0000_0000, 40);
        configure(40'd1000, 5'd0);
        random_burst(115, 40'd60, 35);
        configure(40'd0, 5'd12);
        random_burst(40, 40'd2, 30);
        configure(40'hFF_FFFF_FFFF, 5'd0);
        random_burst(50, 40'd8, 20);

        drain();
        repeat (20) @(negedge aclk);
        end_of_test = 1;
        repeat (3) @(negedge aclk);
        $display("covered %0d requests over nine pool/alignment settings and four idle patterns",
                 n_sent);
        $display("outcomes: %0d ok, %0d out of memory, %0d not found, %0d table full",
                 n_ok, n_nomem, n_notfound, n_full);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
